### design/pls_pkg.sv
package pls_pkg;

  localparam int CapacityDef = 64;
  localparam int DataW       = 32;
  localparam int PosW        = 6;
  localparam int ReqW        = 2;
  localparam int StatW       = 2;
  localparam int CmpW        = 9;

  localparam logic [ReqW-1:0] ReqGet    = 2'd0;
  localparam logic [ReqW-1:0] ReqInsert = 2'd1;
  localparam logic [ReqW-1:0] ReqRemove = 2'd2;

  localparam logic [StatW-1:0] StOk    = 2'd0;
  localparam logic [StatW-1:0] StRange = 2'd1;
  localparam logic [StatW-1:0] StFull  = 2'd2;

  typedef struct packed {
    logic             ins;
    logic             rem;
    logic [PosW-1:0]  pos;
    logic [DataW-1:0] value;
  } cmd_t;

endpackage

### design/pls_cell.sv
module pls_cell #(
  parameter int Index = 0
) (
  input  logic                     clk_i,
  input  pls_pkg::cmd_t            cmd_i,
  input  logic [pls_pkg::DataW-1:0] left_i,
  input  logic [pls_pkg::DataW-1:0] right_i,
  output logic [pls_pkg::DataW-1:0] entry_o
);

  localparam logic [pls_pkg::CmpW-1:0] Me = pls_pkg::CmpW'(Index);

  logic [pls_pkg::DataW-1:0] entry_q, entry_d;
  logic [pls_pkg::CmpW-1:0]  pos;

  assign pos = pls_pkg::CmpW'(cmd_i.pos);

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.ins) begin
      if (Me > pos) begin
        entry_d = left_i;
      end else if (Me == pos) begin
        entry_d = cmd_i.value;
      end
    end else if (cmd_i.rem) begin
      if (Me >= pos) begin
        entry_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

### design/positional_list_store.sv
// Ordered list of signed 32-bit values, held in a row of CAPACITY cells.
// Each item is a get, an insert or a remove at a list position; an insert
// past the end appends. Every item gives one result with the read or removed
// value, the count after the item and a status (ok, position out of range,
// store full). An erroneous item changes nothing. One item is accepted per
// cycle unless the output stalls: on an insert or remove each cell from the
// position up loads from its neighbor or the new value in the same cycle, so
// the whole shift completes at the accepting edge. The result is registered
// at that edge too; a new item is taken while that result waits, unless the
// output is stalled. Entries need no clearing after reset.
module positional_list_store #(
  parameter int CAPACITY = pls_pkg::CapacityDef,
  localparam int CntW = $clog2(CAPACITY + 1)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [pls_pkg::ReqW-1:0]         req_type_i,
  input  logic [pls_pkg::PosW-1:0]         position_i,
  input  logic signed [pls_pkg::DataW-1:0] value_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [pls_pkg::DataW-1:0] data_o,
  output logic [CntW-1:0]                  item_count_o,
  output logic [pls_pkg::StatW-1:0]        status_o
);

  localparam logic [CntW-1:0] CapCnt = CntW'(CAPACITY);

  logic [pls_pkg::DataW-1:0] ent [CAPACITY];
  logic [pls_pkg::DataW-1:0] sel;
  pls_pkg::cmd_t             cmd;

  logic                       acc;
  logic                       full;
  logic                       in_range;
  logic [pls_pkg::CmpW-1:0]   cnt_ext;
  logic [pls_pkg::CmpW-1:0]   pos_ext;
  logic [pls_pkg::PosW-1:0]   ins_pos;

  logic [CntW-1:0]            count_q, count_d;
  logic                       out_valid_q, out_valid_d;
  logic [pls_pkg::DataW-1:0]  data_q, data_d;
  logic [CntW-1:0]            res_cnt_q, res_cnt_d;
  logic [pls_pkg::StatW-1:0]  status_q, status_d;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign acc        = in_valid_i & ~in_stall_o;

  assign cnt_ext  = pls_pkg::CmpW'(count_q);
  assign pos_ext  = pls_pkg::CmpW'(position_i);
  assign in_range = pos_ext < cnt_ext;
  assign full     = count_q == CapCnt;
  assign ins_pos  = (pos_ext > cnt_ext) ? cnt_ext[pls_pkg::PosW-1:0] : position_i;

  always_comb begin
    sel = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (pos_ext == pls_pkg::CmpW'(i)) begin
        sel = sel | ent[i];
      end
    end
  end

  always_comb begin
    cmd.ins   = acc & (req_type_i == pls_pkg::ReqInsert) & ~full;
    cmd.rem   = acc & (req_type_i == pls_pkg::ReqRemove) & in_range;
    cmd.pos   = (req_type_i == pls_pkg::ReqInsert) ? ins_pos : position_i;
    cmd.value = value_i;
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [pls_pkg::DataW-1:0] left, right;
    if (g == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = ent[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = ent[g+1];
    end
    pls_cell #(
      .Index(g)
    ) u_cell (
      .clk_i  (clk_i),
      .cmd_i  (cmd),
      .left_i (left),
      .right_i(right),
      .entry_o(ent[g])
    );
  end

  always_comb begin
    count_d   = count_q;
    data_d    = '0;
    res_cnt_d = count_q;
    status_d  = pls_pkg::StOk;
    unique case (req_type_i)
      pls_pkg::ReqGet: begin
        if (in_range) begin
          data_d = sel;
        end else begin
          status_d = pls_pkg::StRange;
        end
      end
      pls_pkg::ReqInsert: begin
        if (full) begin
          status_d = pls_pkg::StFull;
        end else begin
          res_cnt_d = count_q + CntW'(1);
        end
      end
      pls_pkg::ReqRemove: begin
        if (in_range) begin
          data_d    = sel;
          res_cnt_d = count_q - CntW'(1);
        end else begin
          status_d = pls_pkg::StRange;
        end
      end
      default: begin
        status_d = pls_pkg::StRange;
      end
    endcase
    if (acc) begin
      count_d = res_cnt_d;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (acc) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      data_q    <= data_d;
      res_cnt_q <= res_cnt_d;
      status_q  <= status_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign data_o       = data_q;
  assign item_count_o = res_cnt_q;
  assign status_o     = status_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CapCnt)
    else $error("count above capacity");

  a_count_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !acc |=> $stable(count_q))
    else $error("count moved without an item");

  a_full_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && (req_type_i == pls_pkg::ReqInsert) && full
      |=> (status_o == pls_pkg::StFull) && (item_count_o == CapCnt))
    else $error("insert into full store not flagged");

  a_result_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> out_valid_o && (item_count_o == count_q))
    else $error("result count differs from held count");
`endif

endmodule
